>>> rtl/acht_pkg.sv
// Package: widths, reset levels, ASCII codes and register indexes of the hysteresis tick block
`default_nettype none
package acht_pkg;

    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 10;
    localparam int CH_W        = 2;
    localparam int FIELD_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int ACC_EXT_W   = 14;
    localparam int NUM_CHANNELS_DEF = 4;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [CH_W-1:0]    t_chan;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_level LEVEL_MAX   = 10'd1023;
    localparam t_level LOWER_RESET = 10'd515;
    localparam t_level UPPER_RESET = 10'd530;

    localparam t_byte ASCII_TAB  = 8'h09;
    localparam t_byte ASCII_LF   = 8'h0A;
    localparam t_byte ASCII_ZERO = 8'h30;
    localparam t_byte ASCII_NINE = 8'h39;

    // Low index bit of a register selects the lower (0) or upper (1) level of its channel
    localparam logic CFG_SEL_LOWER = 1'b0;
    localparam logic CFG_SEL_UPPER = 1'b1;

endpackage
`default_nettype wire

>>> rtl/acht_rx_if.sv
// Interface: received byte channel with millisecond time
`default_nettype none
interface acht_rx_if;
    logic             valid;
    logic             ready;
    acht_pkg::t_byte  rx_byte;
    acht_pkg::t_time  now_ms;

    modport source (output valid, output rx_byte, output now_ms, input ready);
    modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface
`default_nettype wire

>>> rtl/acht_tick_if.sv
// Interface: tick result channel
`default_nettype none
interface acht_tick_if;
    logic             valid;
    logic             ready;
    acht_pkg::t_chan  tick_channel;
    acht_pkg::t_time  tick_time_ms;
    acht_pkg::t_level tick_level;

    modport source (output valid, output tick_channel, output tick_time_ms,
                    output tick_level, input ready);
    modport sink   (input valid, input tick_channel, input tick_time_ms,
                    input tick_level, output ready);
endinterface
`default_nettype wire

>>> rtl/ascii_channel_hysteresis_tick.sv
// Top level: ASCII field parser with a per-channel Schmitt trigger tick detector
//
//   channel   direction   payload                                      handshake
//   i_rx      in          rx_byte[7:0], now_ms[31:0]                   valid/ready
//   o_tick    out         tick_channel[1:0], tick_time_ms[31:0],       valid/ready
//                         tick_level[9:0]
//   cfg       in          i_cfg_idx[2:0], i_cfg_data[9:0]              i_cfg_we
//
// One transaction per cycle while the tick output is not stalled; a tick leaves through
// the input register, then the result register. The parse step between them is one
// multiply-by-ten accumulate and one level compare.
// Synchronous active-low reset arms all channels and loads the default levels.
// A stalled result holds the pipeline; the input register still takes one byte.
`default_nettype none
module ascii_channel_hysteresis_tick #(
    parameter int NUM_CHANNELS = acht_pkg::NUM_CHANNELS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    acht_rx_if.sink                i_rx,
    acht_tick_if.source            o_tick,
    input  wire                    i_cfg_we,
    input  wire acht_pkg::t_cfg_idx i_cfg_idx,
    input  wire acht_pkg::t_level  i_cfg_data
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                 r_in_valid;
    acht_pkg::t_byte      r_rx_byte;
    acht_pkg::t_time      r_now_ms;

    acht_pkg::t_level     r_accum;
    acht_pkg::t_field     r_field_idx;
    logic [NUM_CHANNELS-1:0] r_armed;
    acht_pkg::t_level     r_lower [NUM_CHANNELS];
    acht_pkg::t_level     r_upper [NUM_CHANNELS];

    logic                 r_out_valid;
    acht_pkg::t_chan      r_tick_channel;
    acht_pkg::t_time      r_tick_time_ms;
    acht_pkg::t_level     r_tick_level;

    logic                        adv;
    logic                        is_digit;
    logic                        is_sep;
    logic                        in_range;
    logic [CH_IDX_W-1:0]         ch_idx;
    logic [acht_pkg::ACC_EXT_W-1:0] acc_ext;
    logic [acht_pkg::ACC_EXT_W-1:0] acc_sum;
    acht_pkg::t_level            n_accum;
    acht_pkg::t_field            n_field_idx;
    logic                        gen_tick;
    logic                        do_rearm;

    assign adv        = r_in_valid && (!r_out_valid || o_tick.ready);
    assign i_rx.ready = !r_in_valid || adv;

    assign is_digit = (r_rx_byte >= acht_pkg::ASCII_ZERO) && (r_rx_byte <= acht_pkg::ASCII_NINE);
    assign is_sep   = (r_rx_byte == acht_pkg::ASCII_TAB) || (r_rx_byte == acht_pkg::ASCII_LF);
    assign in_range = r_field_idx < acht_pkg::FIELD_W'(NUM_CHANNELS);
    assign ch_idx   = r_field_idx[CH_IDX_W-1:0];

    assign acc_ext = acht_pkg::ACC_EXT_W'(r_accum);
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1)
                   + acht_pkg::ACC_EXT_W'(r_rx_byte[3:0]);

    always_comb begin
        n_accum     = r_accum;
        n_field_idx = r_field_idx;
        gen_tick    = 1'b0;
        do_rearm    = 1'b0;
        if (is_digit) begin
            n_accum = (acc_sum > acht_pkg::ACC_EXT_W'(acht_pkg::LEVEL_MAX))
                    ? acht_pkg::LEVEL_MAX : acc_sum[acht_pkg::LEVEL_W-1:0];
        end else if (is_sep) begin
            if (in_range) begin
                if (r_armed[ch_idx] && (r_accum > r_upper[ch_idx])) begin
                    gen_tick = 1'b1;
                end else if (!r_armed[ch_idx] && (r_accum < r_lower[ch_idx])) begin
                    do_rearm = 1'b1;
                end
                n_field_idx = r_field_idx + acht_pkg::FIELD_W'(1);
            end
            n_accum = '0;
            if (r_rx_byte == acht_pkg::ASCII_LF) begin
                n_field_idx = '0;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_rx_byte <= i_rx.rx_byte;
            r_now_ms  <= i_rx.now_ms;
        end
    end

    // Parser and trigger state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_field_idx <= '0;
            r_armed     <= '1;
        end else if (adv) begin
            r_accum     <= n_accum;
            r_field_idx <= n_field_idx;
            if (gen_tick) begin
                r_armed[ch_idx] <= 1'b0;
            end else if (do_rearm) begin
                r_armed[ch_idx] <= 1'b1;
            end
        end
    end

    // Level registers; writes to absent channels are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_lower[k] <= acht_pkg::LOWER_RESET;
                r_upper[k] <= acht_pkg::UPPER_RESET;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (i_cfg_idx[acht_pkg::CFG_IDX_W-1:1] == acht_pkg::CH_W'(k)) begin
                    if (i_cfg_idx[0] == acht_pkg::CFG_SEL_UPPER) begin
                        r_upper[k] <= i_cfg_data;
                    end else if (i_cfg_idx[0] == acht_pkg::CFG_SEL_LOWER) begin
                        r_lower[k] <= i_cfg_data;
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= gen_tick;
        end else if (o_tick.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && gen_tick) begin
            r_tick_channel <= r_field_idx[acht_pkg::CH_W-1:0];
            r_tick_time_ms <= r_now_ms;
            r_tick_level   <= r_accum;
        end
    end

    assign o_tick.valid        = r_out_valid;
    assign o_tick.tick_channel = r_tick_channel;
    assign o_tick.tick_time_ms = r_tick_time_ms;
    assign o_tick.tick_level   = r_tick_level;

    a_field_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_idx <= acht_pkg::FIELD_W'(NUM_CHANNELS))
        else $error("field index beyond channel count");

    a_digit_no_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && is_digit |-> !gen_tick)
        else $error("digit byte produced a tick");

    a_tick_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && gen_tick |=> r_out_valid)
        else $error("tick not loaded into result register");

    a_tick_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && gen_tick |=> $countones(r_armed) < $countones($past(r_armed)))
        else $error("tick did not disarm its channel");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_rx_byte) && $stable(r_accum))
        else $error("stalled byte lost or state moved");

endmodule
`default_nettype wire

>>> tb/sv/ascii_channel_hysteresis_tick_test.sv
// Testbench: drives ASCII reading lines into the hysteresis tick block and checks every tick
module ascii_channel_hysteresis_tick_test;

    localparam int              RAND_PHASES  = 6;
    localparam int              RAND_ITEMS   = 1200;
    localparam int              HOLD_CYCLES  = 150;
    localparam int              DRAIN_CYCLES = 8;
    localparam int              MAX_REPORTS  = 10;
    localparam acht_pkg::t_time TIME_MAX     = '1;

    typedef struct packed {
        acht_pkg::t_chan  chan;
        acht_pkg::t_time  at_ms;
        acht_pkg::t_level level;
    } t_tick_rec;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    acht_pkg::t_cfg_idx cfg_idx;
    acht_pkg::t_level   cfg_data;

    acht_rx_if   rx_if ();
    acht_tick_if tick_if ();

    ascii_channel_hysteresis_tick dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_tick     (tick_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Tracking copy of the parser and trigger state
    acht_pkg::t_level digit_sum;
    int               field_pos;
    bit  [3:0]        ch_armed;
    acht_pkg::t_level lvl_lo [4];
    acht_pkg::t_level lvl_hi [4];
    t_tick_rec        pending_ticks [$];

    int items_sent;
    int ticks_seen;
    int level_writes;
    int mismatches;
    int hold_left;
    bit tx_idle_en;
    bit rx_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("FAIL ascii_channel_hysteresis_tick");
        $finish;
    end

    task automatic reset_tracking();
        for (int ch = 0; ch < 4; ch++) begin
            lvl_lo[ch] = acht_pkg::LOWER_RESET;
            lvl_hi[ch] = acht_pkg::UPPER_RESET;
        end
        ch_armed  = '1;
        digit_sum = '0;
        field_pos = 0;
    endtask

    task automatic track_reading(input acht_pkg::t_byte b, input acht_pkg::t_time t);
        logic [acht_pkg::ACC_EXT_W-1:0] grown;
        acht_pkg::t_chan                ch;
        if (b >= acht_pkg::ASCII_ZERO && b <= acht_pkg::ASCII_NINE) begin
            grown = acht_pkg::ACC_EXT_W'(digit_sum) * acht_pkg::ACC_EXT_W'(10)
                  + acht_pkg::ACC_EXT_W'(b - acht_pkg::ASCII_ZERO);
            digit_sum = (grown > acht_pkg::ACC_EXT_W'(acht_pkg::LEVEL_MAX))
                      ? acht_pkg::LEVEL_MAX : acht_pkg::t_level'(grown);
        end else if (b == acht_pkg::ASCII_TAB || b == acht_pkg::ASCII_LF) begin
            if (field_pos < acht_pkg::NUM_CHANNELS_DEF) begin
                ch = acht_pkg::t_chan'(field_pos);
                if (ch_armed[ch] && digit_sum > lvl_hi[ch]) begin
                    pending_ticks.push_back('{chan: ch, at_ms: t, level: digit_sum});
                    ch_armed[ch] = 1'b0;
                end else if (!ch_armed[ch] && digit_sum < lvl_lo[ch]) begin
                    ch_armed[ch] = 1'b1;
                end
                field_pos++;
            end
            digit_sum = '0;
            if (b == acht_pkg::ASCII_LF) field_pos = 0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    // Sender side: called and left at a falling edge
    task automatic send_byte(input acht_pkg::t_byte b, input acht_pkg::t_time t);
        while (tx_idle_en && $urandom_range(99) < 24) begin
            rx_if.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        rx_if.now_ms  = t;
        do @(posedge i_clk); while (!rx_if.ready);
        track_reading(b, t);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit edge_times, input bit noisy);
        for (int k = 0; k < s.len(); k++) begin
            if (noisy && $urandom_range(99) < 4) begin
                send_byte(acht_pkg::t_byte'($urandom_range(255)), $urandom);
            end
            if (edge_times) begin
                send_byte(acht_pkg::t_byte'(s[k]),
                          (k % 2 == 1) ? TIME_MAX : acht_pkg::t_time'(0));
            end else begin
                send_byte(acht_pkg::t_byte'(s[k]), $urandom);
            end
        end
    endtask

    task automatic wait_ticks_drained();
        rx_if.valid = 1'b0;
        while (pending_ticks.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_levels(input acht_pkg::t_chan ch, input acht_pkg::t_level lo,
                                input acht_pkg::t_level hi);
        cfg_we   = 1'b1;
        cfg_idx  = acht_pkg::t_cfg_idx'({ch, acht_pkg::CFG_SEL_LOWER});
        cfg_data = lo;
        @(negedge i_clk);
        cfg_idx  = acht_pkg::t_cfg_idx'({ch, acht_pkg::CFG_SEL_UPPER});
        cfg_data = hi;
        @(negedge i_clk);
        cfg_we     = 1'b0;
        lvl_lo[ch] = lo;
        lvl_hi[ch] = hi;
        level_writes += 2;
    endtask

    function automatic string field_text(input int f);
        int    v;
        int    mode;
        string s;
        mode = $urandom_range(9);
        if (mode == 9) return "";
        if (f >= acht_pkg::NUM_CHANNELS_DEF || mode == 7) v = $urandom_range(1023);
        else if (mode == 8) v = $urandom_range(99999, 1024);
        else if (mode < 4) v = int'(lvl_hi[f]) + int'($urandom_range(6)) - 3;
        else v = int'(lvl_lo[f]) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        s = $sformatf("%0d", v);
        if ($urandom_range(7) == 0) s = {"0", s};
        return s;
    endfunction

    task automatic send_random_line();
        int    nf;
        string s;
        nf = $urandom_range(6, 1);
        s  = "";
        for (int f = 0; f < nf; f++) begin
            s = {s, field_text(f)};
            if (f < nf - 1) s = {s, "\t"};
        end
        if ($urandom_range(9) != 0) s = {s, "\n"};
        send_text(s, 1'b0, 1'b1);
    endtask

    task automatic set_phase_levels(input int phase);
        acht_pkg::t_level lo;
        acht_pkg::t_level hi;
        acht_pkg::t_level tmp;
        int               centre;
        int               span;
        for (int ch = 0; ch < 4; ch++) begin
            if (phase == 0) begin
                lo = (ch == 0 || ch == 3) ? acht_pkg::LEVEL_MAX : acht_pkg::t_level'(0);
                hi = (ch == 1 || ch == 3) ? acht_pkg::LEVEL_MAX : acht_pkg::t_level'(0);
            end else begin
                centre = $urandom_range(1023);
                span   = $urandom_range(40);
                lo = (centre < span) ? acht_pkg::t_level'(0)
                                     : acht_pkg::t_level'(centre - span);
                hi = (centre + span > 1023) ? acht_pkg::LEVEL_MAX
                                            : acht_pkg::t_level'(centre + span);
                if ($urandom_range(4) == 0) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            write_levels(acht_pkg::t_chan'(ch), lo, hi);
        end
    endtask

    task automatic test_line_parsing();
        send_text("5-3\r1\t530\t", 1'b1, 1'b0);
        send_byte(8'h00, TIME_MAX);
        send_text("\t9999", 1'b1, 1'b0);
        send_byte(8'hFF, 32'h0);
        send_text("\n\n\t\t\t\t\t7\n", 1'b1, 1'b0);
    endtask

    task automatic test_level_thresholds();
        wait_ticks_drained();
        write_levels(2'd0, acht_pkg::LEVEL_MAX, acht_pkg::LEVEL_MAX);
        write_levels(2'd1, 10'd100, 10'd200);
        write_levels(2'd2, 10'd900, 10'd100);
        write_levels(2'd3, 10'd0, 10'd0);
        send_text("\t201\n\t100\n\t201\n\t99\n\t201\n", 1'b0, 1'b0);
        send_text("\t\t101\n\t\t500\n\t\t101\n", 1'b0, 1'b0);
        send_text("\t\t\t1\n\t\t\t0\n\t\t\t1\n9999\n", 1'b0, 1'b0);
    endtask

    task automatic test_output_stall();
        wait_ticks_drained();
        for (int ch = 0; ch < 4; ch++) begin
            write_levels(acht_pkg::t_chan'(ch), acht_pkg::LOWER_RESET, acht_pkg::UPPER_RESET);
        end
        tx_idle_en = 1'b0;
        send_text("0\t0\t0\t0\n", 1'b0, 1'b0);
        hold_left = HOLD_CYCLES;
        repeat (6) send_text("1000\t1000\t1000\t1000\n0\t0\t0\t0\n", 1'b0, 1'b0);
        tx_idle_en = 1'b1;
        wait_ticks_drained();
    endtask

    task automatic test_random_lines();
        int phase_end;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_ticks_drained();
            set_phase_levels(phase);
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 2);
            phase_end  = items_sent + RAND_ITEMS / RAND_PHASES;
            while (items_sent < phase_end) send_random_line();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Receiver side: ready changes at the falling edge only
    initial begin
        tick_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                tick_if.ready = 1'b0;
                hold_left--;
            end else begin
                tick_if.ready = !(rx_idle_en && $urandom_range(99) < 24);
            end
        end
    end

    always @(posedge i_clk) begin
        t_tick_rec want;
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            ticks_seen++;
            if (pending_ticks.size() == 0) begin
                report_mismatch($sformatf("unexpected tick ch %0d time %0d level %0d",
                    tick_if.tick_channel, tick_if.tick_time_ms, tick_if.tick_level));
            end else begin
                want = pending_ticks.pop_front();
                if (tick_if.tick_channel !== want.chan || tick_if.tick_time_ms !== want.at_ms
                        || tick_if.tick_level !== want.level) begin
                    report_mismatch($sformatf(
                        "expected ch %0d time %0d level %0d, got ch %0d time %0d level %0d",
                        want.chan, want.at_ms, want.level, tick_if.tick_channel,
                        tick_if.tick_time_ms, tick_if.tick_level));
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        rx_if.now_ms  = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_left     = 0;
        items_sent    = 0;
        ticks_seen    = 0;
        level_writes  = 0;
        mismatches    = 0;
        reset_tracking();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_line_parsing();
        test_level_thresholds();
        test_output_stall();
        test_random_lines();
        wait_ticks_drained();

        $display("covered %0d bytes and %0d ticks over %0d level writes,",
            items_sent, ticks_seen, level_writes);
        $display("with crossed and extreme levels, noise bytes and a %0d-cycle output hold",
            HOLD_CYCLES);
        if (mismatches == 0 && pending_ticks.size() == 0) begin
            $display("PASS ascii_channel_hysteresis_tick");
        end else begin
            $display("FAIL ascii_channel_hysteresis_tick");
        end
        $finish;
    end
endmodule

>>> ascii_channel_hysteresis_tick.f
rtl/acht_pkg.sv
rtl/acht_rx_if.sv
rtl/acht_tick_if.sv
rtl/ascii_channel_hysteresis_tick.sv
tb/sv/ascii_channel_hysteresis_tick_test.sv
